[rtl/core/sccr_pkg.sv]
// ----------------------------------------------------------------------------
// sccr_pkg
// Shared types and constants for the sector cache tag and clock policy engine.
// ----------------------------------------------------------------------------
`default_nettype none

package sccr_pkg;

    // Request kinds
    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_FLUSH = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    localparam int unsigned TAG_W     = 32;
    localparam int unsigned SLOT_W    = 6;
    // A flush reports at most this many slots
    localparam int unsigned RES_LIMIT = 64;
    localparam int unsigned RCNT_W    = 7;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SWEEP,
        ST_VREAD,
        ST_VFILL,
        ST_FLUSH,
        ST_FDONE
    } t_state;

    // Per-cycle status of the tag scan unit, aligned with the read data
    typedef struct packed {
        logic vld;     // read data belongs to a scanned slot
        logic last;    // that slot is the final one
        logic match;   // tag equals the compare key
    } t_scan;

endpackage

`default_nettype wire

[rtl/core/sccr_ram.sv]
// ----------------------------------------------------------------------------
// sccr_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sccr_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[rtl/core/sccr_scan.sv]
// ----------------------------------------------------------------------------
// sccr_scan
// Tag scan unit: steps a read address over all slots, one per cycle, and
// compares each returned tag with the key. Shared by lookup and flush.
// ----------------------------------------------------------------------------
`default_nettype none

module sccr_scan #(
    parameter int unsigned NUM_SLOTS = 64
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_go,
    input  wire logic                         i_stop,
    input  wire logic [sccr_pkg::TAG_W-1:0]   i_rdata,
    input  wire logic [sccr_pkg::TAG_W-1:0]   i_key,
    output logic      [$clog2(NUM_SLOTS)-1:0] o_raddr,
    output logic      [$clog2(NUM_SLOTS)-1:0] o_idx,
    output sccr_pkg::t_scan                   o_scan
);

    localparam int unsigned IW = $clog2(NUM_SLOTS);
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);

    logic          r_run,  n_run;
    logic [IW-1:0] r_cnt,  n_cnt;
    logic          r_pvld, n_pvld;
    logic          r_plast;
    logic [IW-1:0] r_pidx;

    // Address counter control
    always_comb begin
        n_run  = r_run;
        n_cnt  = r_cnt;
        n_pvld = r_run & ~i_stop;
        if (i_go) begin
            n_run = 1'b1;
            n_cnt = '0;
        end else if (i_stop) begin
            n_run = 1'b0;
        end else if (r_run) begin
            n_cnt = r_cnt + IW'(1);
            if (r_cnt == LAST_IDX) begin
                n_run = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_cnt  <= '0;
            r_pvld <= 1'b0;
        end else begin
            r_run  <= n_run;
            r_cnt  <= n_cnt;
            r_pvld <= n_pvld;
        end
    end

    // Slot tag of the issued address follows in the next cycle
    always_ff @(posedge i_clk) begin
        r_pidx  <= r_cnt;
        r_plast <= (r_cnt == LAST_IDX);
    end

    assign o_raddr      = r_cnt;
    assign o_idx        = r_pidx;
    assign o_scan.vld   = r_pvld;
    assign o_scan.last  = r_plast;
    assign o_scan.match = (i_rdata == i_key);

endmodule

`default_nettype wire

[rtl/core/sector_cache_clock_replacement_top.sv]
// ----------------------------------------------------------------------------
// sector_cache_clock_replacement_top
// Tag and policy engine of a fully associative write-back sector cache with
// clock (second chance) replacement.
// ----------------------------------------------------------------------------
// Usage:
//   A request (i_kind, i_sector) is taken on a rising edge with start high
//   and busy low. Kinds: read, write, flush all dirty slots; the unused kind
//   is taken and ignored. Results appear on the o_ fields for exactly one
//   cycle with o_valid high; o_last marks the final result of a request.
//   The receiver cannot stall, so every result transfer completes in its
//   strobe cycle.
//   Lookup walks the tag RAM one slot per cycle through the shared scan unit
//   and returns on the first hit. A miss then runs the clock hand one slot
//   per cycle, reads the victim tag and refills it. A flush scans the slots
//   until the last one or the 64th dirty one and emits one result per dirty
//   slot, at most 64 per request, or a single result without writeback when
//   no slot is dirty. busy stays high from the transfer of a read, write or
//   flush request until its last result is strobed; one request is worked
//   at a time, set by the single tag RAM read port. Reset clears valid,
//   dirty and reference bits and the hand at once; no clearing pass is
//   needed, as tag RAM data is only used for valid slots.
// ----------------------------------------------------------------------------
`default_nettype none

module sector_cache_clock_replacement_top #(
    parameter int unsigned NUM_SLOTS = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [1:0]                  i_kind,
    input  wire logic [sccr_pkg::TAG_W-1:0]  i_sector,
    output logic                             o_valid,
    output logic                             o_hit,
    output logic      [sccr_pkg::SLOT_W-1:0] o_slot,
    output logic                             o_writeback_valid,
    output logic      [sccr_pkg::TAG_W-1:0]  o_writeback_sector,
    output logic                             o_fill_valid,
    output logic                             o_last
);

    localparam int unsigned IW = $clog2(NUM_SLOTS);
    localparam int unsigned SW = sccr_pkg::SLOT_W;
    localparam int unsigned TW = sccr_pkg::TAG_W;
    localparam int unsigned CW = sccr_pkg::RCNT_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);
    localparam logic [CW-1:0] LIM_M1   = CW'(sccr_pkg::RES_LIMIT - 1);

    sccr_pkg::t_state r_state, n_state;

    // Request and policy state
    logic [1:0]           r_kind,   n_kind;
    logic [TW-1:0]        r_sector, n_sector;
    logic [IW-1:0]        r_hand,   n_hand;
    logic [IW-1:0]        r_victim, n_victim;
    logic [NUM_SLOTS-1:0] r_valid,  n_valid;
    logic [NUM_SLOTS-1:0] r_dirty,  n_dirty;
    logic [NUM_SLOTS-1:0] r_ref,    n_ref;

    // Flush holding stage: one result held back so the final one gets last
    logic                 r_fhave,  n_fhave;
    logic [IW-1:0]        r_fidx,   n_fidx;
    logic [TW-1:0]        r_fsec,   n_fsec;
    logic [CW-1:0]        r_fcnt,   n_fcnt;

    // Result registers
    logic                 r_ovld,   n_ovld;
    logic                 r_ohit,   n_ohit;
    logic [IW-1:0]        r_oidx,   n_oidx;
    logic                 r_owbv,   n_owbv;
    logic [TW-1:0]        r_owbs,   n_owbs;
    logic                 r_ofill,  n_ofill;
    logic                 r_olast,  n_olast;

    // Scan unit and tag RAM
    logic                 w_go, w_stop, w_we;
    logic [IW-1:0]        w_scan_raddr, w_raddr, w_idx;
    logic [TW-1:0]        w_rdata;
    sccr_pkg::t_scan      w_scan;

    logic                 w_accept, w_hit, w_fcap, w_sweep_skip;
    logic [IW-1:0]        w_hand_next;
    logic [IW+SW-1:0]     w_slot_ext;

    sccr_scan #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_go),
        .i_stop  (w_stop),
        .i_rdata (w_rdata),
        .i_key   (r_sector),
        .o_raddr (w_scan_raddr),
        .o_idx   (w_idx),
        .o_scan  (w_scan)
    );

    sccr_ram #(
        .WIDTH (TW),
        .DEPTH (NUM_SLOTS)
    ) u_tags (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_victim),
        .i_wdata (r_sector),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Handshake and per-cycle decisions
    assign busy         = (r_state != sccr_pkg::ST_IDLE);
    assign w_accept     = start & ~busy;
    assign w_hit        = w_scan.vld & r_valid[w_idx] & w_scan.match;
    assign w_fcap       = w_scan.vld & r_valid[w_idx] & r_dirty[w_idx];
    assign w_sweep_skip = r_valid[r_hand] & r_ref[r_hand];
    assign w_hand_next  = (r_hand == LAST_IDX) ? '0 : r_hand + IW'(1);
    assign w_raddr      = (r_state == sccr_pkg::ST_VREAD) ? r_victim : w_scan_raddr;
    assign w_we         = (r_state == sccr_pkg::ST_VFILL);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sccr_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (i_kind inside {sccr_pkg::KIND_READ, sccr_pkg::KIND_WRITE}) begin
                        n_state = sccr_pkg::ST_SEARCH;
                    end else if (i_kind == sccr_pkg::KIND_FLUSH) begin
                        n_state = sccr_pkg::ST_FLUSH;
                    end
                end
            end
            sccr_pkg::ST_SEARCH: begin
                if (w_hit) begin
                    n_state = sccr_pkg::ST_IDLE;
                end else if (w_scan.vld && w_scan.last) begin
                    n_state = sccr_pkg::ST_SWEEP;
                end
            end
            sccr_pkg::ST_SWEEP: begin
                if (!w_sweep_skip) begin
                    n_state = sccr_pkg::ST_VREAD;
                end
            end
            sccr_pkg::ST_VREAD: n_state = sccr_pkg::ST_VFILL;
            sccr_pkg::ST_VFILL: n_state = sccr_pkg::ST_IDLE;
            sccr_pkg::ST_FLUSH: begin
                if ((w_fcap && r_fcnt == LIM_M1) || (w_scan.vld && w_scan.last)) begin
                    n_state = sccr_pkg::ST_FDONE;
                end
            end
            sccr_pkg::ST_FDONE: n_state = sccr_pkg::ST_IDLE;
            default:            n_state = sccr_pkg::ST_IDLE;
        endcase
    end

    // State updates and results
    always_comb begin
        n_kind   = r_kind;
        n_sector = r_sector;
        n_hand   = r_hand;
        n_victim = r_victim;
        n_valid  = r_valid;
        n_dirty  = r_dirty;
        n_ref    = r_ref;
        n_fhave  = r_fhave;
        n_fidx   = r_fidx;
        n_fsec   = r_fsec;
        n_fcnt   = r_fcnt;
        n_ovld   = 1'b0;
        n_ohit   = 1'b0;
        n_oidx   = '0;
        n_owbv   = 1'b0;
        n_owbs   = '0;
        n_ofill  = 1'b0;
        n_olast  = 1'b0;
        w_go     = 1'b0;
        w_stop   = 1'b0;
        case (r_state)
            sccr_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_kind   = i_kind;
                    n_sector = i_sector;
                    n_fhave  = 1'b0;
                    n_fcnt   = '0;
                    w_go     = (i_kind != sccr_pkg::KIND_NONE);
                end
            end
            sccr_pkg::ST_SEARCH: begin
                if (w_hit) begin
                    w_stop       = 1'b1;
                    n_ref[w_idx] = 1'b1;
                    if (r_kind == sccr_pkg::KIND_WRITE) begin
                        n_dirty[w_idx] = 1'b1;
                    end
                    n_ovld  = 1'b1;
                    n_ohit  = 1'b1;
                    n_oidx  = w_idx;
                    n_olast = 1'b1;
                end
            end
            sccr_pkg::ST_SWEEP: begin
                // Second chance: clear set ref bit or pick victim; hand steps
                n_hand = w_hand_next;
                if (w_sweep_skip) begin
                    n_ref[r_hand] = 1'b0;
                end else begin
                    n_victim = r_hand;
                end
            end
            sccr_pkg::ST_VREAD: begin
                // victim tag read in flight
            end
            sccr_pkg::ST_VFILL: begin
                n_ovld  = 1'b1;
                n_oidx  = r_victim;
                n_owbv  = r_valid[r_victim] & r_dirty[r_victim];
                n_owbs  = (r_valid[r_victim] & r_dirty[r_victim]) ? w_rdata : '0;
                n_ofill = 1'b1;
                n_olast = 1'b1;
                n_valid[r_victim] = 1'b1;
                n_ref[r_victim]   = 1'b1;
                n_dirty[r_victim] = (r_kind == sccr_pkg::KIND_WRITE);
            end
            sccr_pkg::ST_FLUSH: begin
                if (w_fcap) begin
                    n_dirty[w_idx] = 1'b0;
                    if (r_fhave) begin
                        n_ovld = 1'b1;
                        n_oidx = r_fidx;
                        n_owbv = 1'b1;
                        n_owbs = r_fsec;
                    end
                    n_fhave = 1'b1;
                    n_fidx  = w_idx;
                    n_fsec  = w_rdata;
                    n_fcnt  = r_fcnt + CW'(1);
                    w_stop  = (r_fcnt == LIM_M1);
                end
            end
            sccr_pkg::ST_FDONE: begin
                n_ovld  = 1'b1;
                n_olast = 1'b1;
                if (r_fhave) begin
                    n_oidx = r_fidx;
                    n_owbv = 1'b1;
                    n_owbs = r_fsec;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sccr_pkg::ST_IDLE;
            r_hand  <= '0;
            r_valid <= '0;
            r_dirty <= '0;
            r_ref   <= '0;
            r_fhave <= 1'b0;
            r_fcnt  <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_hand  <= n_hand;
            r_valid <= n_valid;
            r_dirty <= n_dirty;
            r_ref   <= n_ref;
            r_fhave <= n_fhave;
            r_fcnt  <= n_fcnt;
            r_ovld  <= n_ovld;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_sector <= n_sector;
        r_victim <= n_victim;
        r_fidx   <= n_fidx;
        r_fsec   <= n_fsec;
        r_ohit   <= n_ohit;
        r_oidx   <= n_oidx;
        r_owbv   <= n_owbv;
        r_owbs   <= n_owbs;
        r_ofill  <= n_ofill;
        r_olast  <= n_olast;
    end

    // Slot number is reported modulo 64
    assign w_slot_ext = {{SW{1'b0}}, r_oidx};

    assign o_valid            = r_ovld;
    assign o_hit              = r_ohit;
    assign o_slot             = w_slot_ext[SW-1:0];
    assign o_writeback_valid  = r_owbv;
    assign o_writeback_sector = r_owbs;
    assign o_fill_valid       = r_ofill;
    assign o_last             = r_olast;

endmodule

`default_nettype wire
